FILE: src/msp_pkg.sv
`timescale 1ns / 1ps

package msp_pkg;

  // data path and configuration widths
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_IDX_W = 3;

  // default matrix bounds
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  // register reset values
  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 4'd8;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;

  // extremes of the signed element range
  localparam logic signed [DATA_W-1:0] INT_MAX_V = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] INT_MIN_V = 32'sh8000_0000;

  // one classified element on its way from front to back
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     row_end;
    logic                     mat_end;
  } q_entry_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_LOAD,
    BK_READ,
    BK_CMP,
    BK_FLUSH
  } back_state_t;

endpackage

FILE: src/msp_elem_if.sv
`timescale 1ns / 1ps

interface msp_elem_if
  import msp_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

FILE: src/msp_res_if.sv
`timescale 1ns / 1ps

interface msp_res_if
  import msp_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     saddle_valid;
  logic [OUT_IDX_W-1:0]     saddle_row;
  logic [OUT_IDX_W-1:0]     saddle_col;
  logic signed [DATA_W-1:0] saddle_value;
  logic                     zero_found;
  logic [OUT_IDX_W-1:0]     first_zero_row;
  logic                     last;

  modport source (
    output valid, output saddle_valid, output saddle_row, output saddle_col,
    output saddle_value, output zero_found, output first_zero_row, output last,
    input ready
  );
  modport sink (
    input valid, input saddle_valid, input saddle_row, input saddle_col,
    input saddle_value, input zero_found, input first_zero_row, input last,
    output ready
  );
endinterface

FILE: src/msp_ram.sv
`timescale 1ns / 1ps

module msp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/msp_queue.sv
`timescale 1ns / 1ps

module msp_queue
  import msp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  q_entry_t   buf_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = buf_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wptr_nxt  = do_push ? ~wptr_r : wptr_r;
    rptr_nxt  = do_pop ? ~rptr_r : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      buf_r[wptr_r] <= push_entry;
    end
  end

endmodule

FILE: src/msp_front.sv
`timescale 1ns / 1ps

module msp_front
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clear,
  input  logic [RW-1:0]   rows_last,
  input  logic [CW-1:0]   cols_last,
  msp_elem_if.sink        in_elem,
  output logic            push_valid,
  input  logic            push_ready,
  output q_entry_t        push_entry
);

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          accept;
  logic          row_end;

  assign in_elem.ready = push_ready;
  assign push_valid    = in_elem.valid;
  assign accept        = in_elem.valid && push_ready;

  // tag each element with its place in the matrix
  assign row_end               = (col_r == cols_last);
  assign push_entry.value      = in_elem.element_value;
  assign push_entry.row_end    = row_end;
  assign push_entry.mat_end    = row_end && (row_r == rows_last);

  // row-major position counters
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (clear) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = (row_r == rows_last) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

FILE: src/msp_back.sv
`timescale 1ns / 1ps

module msp_back
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int DEPTH = MAX_ROWS * MAX_COLS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic [RW-1:0] rows_last,
  input  logic [CW-1:0] cols_last,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  q_entry_t      pop_entry,
  msp_res_if.source     out_res
);

  back_state_t state_r, state_nxt;

  // running statistics: column maxima and row minima kept as rotating rings
  logic signed [DATA_W-1:0] cmax_r [MAX_COLS];
  logic signed [DATA_W-1:0] rmin_r [MAX_ROWS];
  logic signed [DATA_W-1:0] rcur_r, rcur_nxt;
  logic                     zero_seen_r, zero_seen_nxt;
  logic [RW-1:0]            zero_row_r, zero_row_nxt;

  // load and scan counters
  logic [AW-1:0] ld_addr_r, ld_addr_nxt;
  logic [RW-1:0] ld_row_r, ld_row_nxt;
  logic [AW-1:0] sc_addr_r, sc_addr_nxt;
  logic [RW-1:0] sc_row_r, sc_row_nxt;
  logic [CW-1:0] sc_col_r, sc_col_nxt;

  // held-back match, so the final one can be flagged last
  logic                     pend_valid_r, pend_valid_nxt;
  logic [RW-1:0]            pend_row_r, pend_row_nxt;
  logic [CW-1:0]            pend_col_r, pend_col_nxt;
  logic signed [DATA_W-1:0] pend_val_r, pend_val_nxt;

  // output register
  logic                     ov_r, ov_nxt;
  logic                     o_sv_r, o_sv_nxt;
  logic [OUT_IDX_W-1:0]     o_row_r, o_row_nxt;
  logic [OUT_IDX_W-1:0]     o_col_r, o_col_nxt;
  logic signed [DATA_W-1:0] o_val_r, o_val_nxt;
  logic                     o_zf_r, o_zf_nxt;
  logic [OUT_IDX_W-1:0]     o_fzr_r, o_fzr_nxt;
  logic                     o_last_r, o_last_nxt;

  // ring controls
  logic                     cmax_shift, rmin_shift;
  logic signed [DATA_W-1:0] cmax_head_new, rmin_tail_new;
  logic                     run_clear, flush_clear;

  // element store
  logic                     ram_we;
  logic signed [DATA_W-1:0] ram_rdata;

  logic signed [DATA_W-1:0] v, row_min_new;
  logic                     hit, out_free, can_go, scan_end;

  msp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_addr_r),
    .wdata (pop_entry.value),
    .raddr (sc_addr_r),
    .rdata (ram_rdata)
  );

  assign v           = pop_entry.value;
  assign row_min_new = (v < rcur_r) ? v : rcur_r;
  assign hit         = (ram_rdata == rmin_r[0]) && (ram_rdata == cmax_r[0]);
  assign out_free    = !ov_r || out_res.ready;
  assign can_go      = !(hit && pend_valid_r) || out_free;
  assign scan_end    = (sc_row_r == rows_last) && (sc_col_r == cols_last);
  assign run_clear   = clear || flush_clear;

  // sequencer: load, then read and compare each stored element, then flush
  always_comb begin
    state_nxt      = state_r;
    pop_ready      = 1'b0;
    ram_we         = 1'b0;
    cmax_shift     = 1'b0;
    cmax_head_new  = cmax_r[0];
    rmin_shift     = 1'b0;
    rmin_tail_new  = rmin_r[0];
    flush_clear    = 1'b0;
    rcur_nxt       = rcur_r;
    zero_seen_nxt  = zero_seen_r;
    zero_row_nxt   = zero_row_r;
    ld_addr_nxt    = ld_addr_r;
    ld_row_nxt     = ld_row_r;
    sc_addr_nxt    = sc_addr_r;
    sc_row_nxt     = sc_row_r;
    sc_col_nxt     = sc_col_r;
    pend_valid_nxt = pend_valid_r;
    pend_row_nxt   = pend_row_r;
    pend_col_nxt   = pend_col_r;
    pend_val_nxt   = pend_val_r;
    ov_nxt         = ov_r && !out_res.ready;
    o_sv_nxt       = o_sv_r;
    o_row_nxt      = o_row_r;
    o_col_nxt      = o_col_r;
    o_val_nxt      = o_val_r;
    o_zf_nxt       = o_zf_r;
    o_fzr_nxt      = o_fzr_r;
    o_last_nxt     = o_last_r;

    case (state_r)
      BK_LOAD: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          ram_we        = 1'b1;
          cmax_shift    = 1'b1;
          cmax_head_new = (v > cmax_r[0]) ? v : cmax_r[0];
          if (v == '0 && !zero_seen_r) begin
            zero_seen_nxt = 1'b1;
            zero_row_nxt  = ld_row_r;
          end
          ld_addr_nxt = ld_addr_r + AW'(1);
          if (pop_entry.row_end) begin
            rmin_shift    = 1'b1;
            rmin_tail_new = row_min_new;
            rcur_nxt      = INT_MAX_V;
            ld_row_nxt    = ld_row_r + RW'(1);
          end else begin
            rcur_nxt = row_min_new;
          end
          if (pop_entry.mat_end) begin
            ld_addr_nxt = '0;
            ld_row_nxt  = '0;
            sc_addr_nxt = '0;
            sc_row_nxt  = '0;
            sc_col_nxt  = '0;
            state_nxt   = BK_READ;
          end
        end
      end

      BK_READ: begin
        state_nxt = BK_CMP;
      end

      BK_CMP: begin
        if (can_go) begin
          if (hit) begin
            if (pend_valid_r) begin
              ov_nxt     = 1'b1;
              o_sv_nxt   = 1'b1;
              o_row_nxt  = OUT_IDX_W'(pend_row_r);
              o_col_nxt  = OUT_IDX_W'(pend_col_r);
              o_val_nxt  = pend_val_r;
              o_zf_nxt   = zero_seen_r;
              o_fzr_nxt  = OUT_IDX_W'(zero_row_r);
              o_last_nxt = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_row_nxt   = sc_row_r;
            pend_col_nxt   = sc_col_r;
            pend_val_nxt   = ram_rdata;
          end
          cmax_shift  = 1'b1;
          sc_addr_nxt = sc_addr_r + AW'(1);
          if (sc_col_r == cols_last) begin
            rmin_shift = 1'b1;
            sc_col_nxt = '0;
            sc_row_nxt = sc_row_r + RW'(1);
          end else begin
            sc_col_nxt = sc_col_r + CW'(1);
          end
          state_nxt = scan_end ? BK_FLUSH : BK_READ;
        end
      end

      BK_FLUSH: begin
        if (out_free) begin
          ov_nxt         = 1'b1;
          o_sv_nxt       = pend_valid_r;
          o_row_nxt      = pend_valid_r ? OUT_IDX_W'(pend_row_r) : '0;
          o_col_nxt      = pend_valid_r ? OUT_IDX_W'(pend_col_r) : '0;
          o_val_nxt      = pend_valid_r ? pend_val_r : '0;
          o_zf_nxt       = zero_seen_r;
          o_fzr_nxt      = OUT_IDX_W'(zero_row_r);
          o_last_nxt     = 1'b1;
          pend_valid_nxt = 1'b0;
          flush_clear    = 1'b1;
          state_nxt      = BK_LOAD;
        end
      end

      default: begin
        state_nxt = BK_LOAD;
      end
    endcase

    // restart of the run: statistics and load position back to reset
    if (run_clear) begin
      rcur_nxt      = INT_MAX_V;
      zero_seen_nxt = 1'b0;
      zero_row_nxt  = '0;
      ld_addr_nxt   = '0;
      ld_row_nxt    = '0;
    end
    if (clear) begin
      state_nxt      = BK_LOAD;
      pend_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_LOAD;
      rcur_r       <= INT_MAX_V;
      zero_seen_r  <= 1'b0;
      zero_row_r   <= '0;
      ld_addr_r    <= '0;
      ld_row_r     <= '0;
      sc_addr_r    <= '0;
      sc_row_r     <= '0;
      sc_col_r     <= '0;
      pend_valid_r <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rcur_r       <= rcur_nxt;
      zero_seen_r  <= zero_seen_nxt;
      zero_row_r   <= zero_row_nxt;
      ld_addr_r    <= ld_addr_nxt;
      ld_row_r     <= ld_row_nxt;
      sc_addr_r    <= sc_addr_nxt;
      sc_row_r     <= sc_row_nxt;
      sc_col_r     <= sc_col_nxt;
      pend_valid_r <= pend_valid_nxt;
      ov_r         <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    pend_val_r <= pend_val_nxt;
    o_sv_r     <= o_sv_nxt;
    o_row_r    <= o_row_nxt;
    o_col_r    <= o_col_nxt;
    o_val_r    <= o_val_nxt;
    o_zf_r     <= o_zf_nxt;
    o_fzr_r    <= o_fzr_nxt;
    o_last_r   <= o_last_nxt;
  end

  // column maxima ring: head is the current column, wraps at the last column
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cmax
    localparam int NXT = (k < MAX_COLS - 1) ? k + 1 : k;
    always_ff @(posedge clk) begin
      if (!rst_n || run_clear) begin
        cmax_r[k] <= INT_MIN_V;
      end else if (cmax_shift) begin
        if (CW'(k) == cols_last) begin
          cmax_r[k] <= cmax_head_new;
        end else begin
          cmax_r[k] <= cmax_r[NXT];
        end
      end
    end
  end

  // row minima ring: filled at each row end, rotated row by row in the scan
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_rmin
    localparam int NXT = (k < MAX_ROWS - 1) ? k + 1 : k;
    always_ff @(posedge clk) begin
      if (!rst_n || run_clear) begin
        rmin_r[k] <= INT_MAX_V;
      end else if (rmin_shift) begin
        if (RW'(k) == rows_last) begin
          rmin_r[k] <= rmin_tail_new;
        end else begin
          rmin_r[k] <= rmin_r[NXT];
        end
      end
    end
  end

  assign out_res.valid          = ov_r;
  assign out_res.saddle_valid   = o_sv_r;
  assign out_res.saddle_row     = o_row_r;
  assign out_res.saddle_col     = o_col_r;
  assign out_res.saddle_value   = o_val_r;
  assign out_res.zero_found     = o_zf_r;
  assign out_res.first_zero_row = o_fzr_r;
  assign out_res.last           = o_last_r;

endmodule

FILE: src/matrix_saddle_point_finder.sv
`timescale 1ns / 1ps
// channel   port       direction  payload
// --------  ---------  ---------  -----------------------------------------------
// elements  in_elem    sink       element_value
// results   out_res    source     saddle_valid, saddle_row, saddle_col,
//                                 saddle_value, zero_found, first_zero_row, last
// config    cfg_*      write      cfg_we, cfg_index, cfg_wdata
//
// Loading takes one element per cycle through a two-entry queue into the back end,
// except while the back end scans. After the last element the back end scans the
// element RAM one element at a time (registered read, then compare) and then
// flushes the final result; the front keeps filling the queue meanwhile.
// Synchronous active-low reset; no clearing pass. A held output stalls the scan.

module matrix_saddle_point_finder
  import msp_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  msp_elem_if.sink             in_elem,
  msp_res_if.source            out_res
);

  logic [CFG_W-1:0] num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0] num_cols_r, num_cols_nxt;
  logic             cfg_clear;
  logic [RW-1:0]    rows_last;
  logic [CW-1:0]    cols_last;

  logic     push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_entry, pop_entry;

  // register writes; any known index restarts the run
  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    cfg_clear    = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_ROWS: begin
          num_rows_nxt = cfg_wdata;
          cfg_clear    = 1'b1;
        end
        CFG_NUM_COLS: begin
          num_cols_nxt = cfg_wdata;
          cfg_clear    = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= NUM_ROWS_RST;
      num_cols_r <= NUM_COLS_RST;
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  // saturate dimensions into 1..max, kept as last index
  always_comb begin
    if (num_rows_r == '0) begin
      rows_last = '0;
    end else if (int'(num_rows_r) > MAX_ROWS) begin
      rows_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_last = RW'(num_rows_r - CFG_W'(1));
    end
    if (num_cols_r == '0) begin
      cols_last = '0;
    end else if (int'(num_cols_r) > MAX_COLS) begin
      cols_last = CW'(MAX_COLS - 1);
    end else begin
      cols_last = CW'(num_cols_r - CFG_W'(1));
    end
  end

  msp_front #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (cfg_clear),
    .rows_last  (rows_last),
    .cols_last  (cols_last),
    .in_elem    (in_elem),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  msp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  msp_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_clear),
    .rows_last (rows_last),
    .cols_last (cols_last),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_res   (out_res)
  );

endmodule

FILE: tb/saddle_report_checker.sv
`timescale 1ns / 1ps

module saddle_report_checker
  import msp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  msp_elem_if                  elem,
  msp_res_if                   res,
  output int                   mismatch_count,
  output int                   reports_pending
);

  // one result transaction as seen on the result channel
  typedef struct packed {
    logic                     saddle_valid;
    logic [OUT_IDX_W-1:0]     row;
    logic [OUT_IDX_W-1:0]     col;
    logic signed [DATA_W-1:0] value;
    logic                     zero_found;
    logic [OUT_IDX_W-1:0]     zero_row;
    logic                     last;
  } saddle_report_t;

  localparam int STORE_DEPTH = MAX_ROWS_DEF * MAX_COLS_DEF;

  // shadow of the registers and the loading state
  logic [CFG_W-1:0]         rows_raw;
  logic [CFG_W-1:0]         cols_raw;
  logic signed [DATA_W-1:0] element_store [STORE_DEPTH];
  logic signed [DATA_W-1:0] row_min [MAX_ROWS_DEF];
  logic signed [DATA_W-1:0] col_max [MAX_COLS_DEF];
  int                       load_count;
  logic                     zero_seen;
  logic [OUT_IDX_W-1:0]     zero_row;

  saddle_report_t expected_reports [$];
  int             fail_tally = 0;
  int             pending_n = 0;

  assign mismatch_count  = fail_tally;
  assign reports_pending = pending_n;

  // register value to dimension in use: zero counts as one, saturate at the max
  function automatic int eff_dim(input logic [CFG_W-1:0] raw, input int cap);
    if (raw == '0) return 1;
    if (int'(raw) > cap) return cap;
    return int'(raw);
  endfunction

  function automatic void restart_load();
    for (int k = 0; k < MAX_ROWS_DEF; k++) row_min[k] = INT_MAX_V;
    for (int k = 0; k < MAX_COLS_DEF; k++) col_max[k] = INT_MIN_V;
    load_count = 0;
    zero_seen  = 1'b0;
    zero_row   = '0;
  endfunction

  // zero tracking is final once the matrix is complete, so every report carries it
  function automatic saddle_report_t make_report(input logic ok, input int r, input int c,
                                                 input logic signed [DATA_W-1:0] v);
    saddle_report_t rep;
    rep.saddle_valid = ok;
    rep.row          = r[OUT_IDX_W-1:0];
    rep.col          = c[OUT_IDX_W-1:0];
    rep.value        = v;
    rep.zero_found   = zero_seen;
    rep.zero_row     = zero_row;
    rep.last         = 1'b0;
    return rep;
  endfunction

  function automatic string describe(input saddle_report_t rep);
    return $sformatf("{sv=%0b row=%0d col=%0d val=%0d zf=%0b zrow=%0d last=%0b}",
                     rep.saddle_valid, rep.row, rep.col, rep.value, rep.zero_found,
                     rep.zero_row, rep.last);
  endfunction

  // predict on accepted elements, compare on accepted results
  always @(posedge clk) begin : predict
    saddle_report_t           got;
    saddle_report_t           want;
    saddle_report_t           held;
    logic                     have_held;
    int                       n_rows;
    int                       n_cols;
    int                       total;
    int                       r;
    int                       c;
    logic signed [DATA_W-1:0] v;
    if (!rst_n) begin
      rows_raw = NUM_ROWS_RST;
      cols_raw = NUM_COLS_RST;
      restart_load();
      expected_reports.delete();
    end else begin
      // any write to a known register restarts loading
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_ROWS: begin
            rows_raw = cfg_wdata;
            restart_load();
          end
          CFG_NUM_COLS: begin
            cols_raw = cfg_wdata;
            restart_load();
          end
          default: ;
        endcase
      end

      // element transaction: update running min/max and zero tracking
      if (elem.valid && elem.ready) begin
        n_rows = eff_dim(rows_raw, MAX_ROWS_DEF);
        n_cols = eff_dim(cols_raw, MAX_COLS_DEF);
        total  = n_rows * n_cols;
        if (load_count >= total) load_count = 0;
        r = load_count / n_cols;
        c = load_count % n_cols;
        v = elem.element_value;
        element_store[load_count] = v;
        if (v < row_min[r]) row_min[r] = v;
        if (v > col_max[c]) col_max[c] = v;
        if (v == '0 && !zero_seen) begin
          zero_seen = 1'b1;
          zero_row  = r[OUT_IDX_W-1:0];
        end
        load_count++;

        // matrix complete: scan in row-major order, flag the final report
        if (load_count == total) begin
          have_held = 1'b0;
          for (int k = 0; k < total; k++) begin
            r = k / n_cols;
            c = k % n_cols;
            v = element_store[k];
            if (v == row_min[r] && v == col_max[c]) begin
              if (have_held) expected_reports.push_back(held);
              held      = make_report(1'b1, r, c, v);
              have_held = 1'b1;
            end
          end
          if (!have_held) held = make_report(1'b0, 0, 0, '0);
          held.last = 1'b1;
          expected_reports.push_back(held);
          restart_load();
        end
      end

      // result transaction
      if (res.valid && res.ready) begin
        got.saddle_valid = res.saddle_valid;
        got.row          = res.saddle_row;
        got.col          = res.saddle_col;
        got.value        = res.saddle_value;
        got.zero_found   = res.zero_found;
        got.zero_row     = res.first_zero_row;
        got.last         = res.last;
        if (expected_reports.size() == 0) begin
          fail_tally++;
          $display("%0t: unexpected result, expected none, actual %s", $time, describe(got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            fail_tally++;
            $display("%0t: result mismatch, expected %s, actual %s", $time,
                     describe(want), describe(got));
          end
        end
      end
    end
    pending_n = expected_reports.size();
  end

endmodule

FILE: tb/matrix_saddle_point_finder_tb.sv
`timescale 1ns / 1ps

module matrix_saddle_point_finder_tb;
  import msp_pkg::*;

  localparam int ITEM_TARGET   = 470;
  localparam int MATRIX_TARGET = 20;
  localparam int QUIET_FROM    = 400;
  localparam int IDLE_GAP      = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int TAIL_CYCLES   = 160;
  localparam int CYCLE_LIMIT   = 400000;

  // indexes past the register list, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef enum {FILL_TINY, FILL_SADDLE, FILL_WIDE} fill_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int report_fails;
  int pending;

  msp_elem_if elem_ch ();
  msp_res_if  res_ch ();

  matrix_saddle_point_finder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_elem   (elem_ch),
    .out_res   (res_ch)
  );

  saddle_report_checker report_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .elem            (elem_ch),
    .res             (res_ch),
    .mismatch_count  (report_fails),
    .reports_pending (pending)
  );

  // stimulus-side state
  int               src_gap_pct = 20;
  int               snk_gap_pct = 20;
  int               hold_requests = 0;
  int               holds_done = 0;
  int               items_sent = 0;
  int               matrices_done = 0;
  int               cur_rows = 8;
  int               cur_cols = 8;
  logic [CFG_W-1:0] rows_raw = NUM_ROWS_RST;
  int               cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Mismatches found");
    $finish;
  end

  // result side: random stall bursts, plus long holds on request
  initial begin
    res_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (holds_done < hold_requests) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end else if (snk_gap_pct != 0 && $urandom_range(0, 99) < snk_gap_pct) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] clip32(input longint x);
    if (x > longint'(INT_MAX_V)) return INT_MAX_V;
    if (x < longint'(INT_MIN_V)) return INT_MIN_V;
    return x[DATA_W-1:0];
  endfunction

  // register value, mostly small dimensions, sometimes zero or past the max
  function automatic logic [CFG_W-1:0] pick_dim();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return CFG_W'($urandom_range(9, 15));
    if (sel < 4) return CFG_W'(8);
    if (sel < 7) return CFG_W'($urandom_range(5, 7));
    return CFG_W'($urandom_range(1, 4));
  endfunction

  function automatic int gap_choice();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // one element transaction, with an optional idle burst ahead of it
  task automatic send_elem(input logic signed [DATA_W-1:0] v);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      elem_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.element_value <= v;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // input stays idle around a register write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    elem_ch.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every expected result, then let the front end drain
  task automatic settle();
    elem_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_GAP) @(negedge clk);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] r_raw, input logic [CFG_W-1:0] c_raw);
    cfg_write(CFG_NUM_ROWS, r_raw);
    cfg_write(CFG_NUM_COLS, c_raw);
    rows_raw = r_raw;
    cur_rows = (r_raw == '0) ? 1 : (r_raw > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(r_raw);
    cur_cols = (c_raw == '0) ? 1 : (c_raw > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(c_raw);
  endtask

  // send the first count elements of a matrix at the current dimensions
  task automatic send_matrix(input fill_mode_t mode, input int count);
    int                       sr;
    int                       sc;
    int                       i;
    int                       j;
    int                       off;
    logic signed [DATA_W-1:0] base;
    logic signed [DATA_W-1:0] v;
    sr = $urandom_range(0, cur_rows - 1);
    sc = $urandom_range(0, cur_cols - 1);
    case ($urandom_range(0, 3))
      0: base = INT_MIN_V;
      1: base = INT_MAX_V;
      2: base = $urandom();
      default: base = $urandom_range(0, 100) - 50;
    endcase
    for (int k = 0; k < count; k++) begin
      i = k / cur_cols;
      j = k % cur_cols;
      case (mode)
        // narrow range: ties, zeros and chance saddle points
        FILL_TINY: v = $urandom_range(0, 4) - 2;
        // planted saddle: its row never below it, its column never above it
        FILL_SADDLE: begin
          if (i == sr && j == sc) begin
            v = base;
          end else if (i == sr) begin
            off = $urandom_range(0, 3);
            v   = clip32(longint'(base) + off);
          end else if (j == sc) begin
            off = $urandom_range(0, 3);
            v   = clip32(longint'(base) - off);
          end else begin
            off = $urandom_range(0, 12);
            v   = clip32(longint'(base) + off - 6);
          end
        end
        default: begin
          case ($urandom_range(0, 7))
            0: v = INT_MIN_V;
            1: v = INT_MAX_V;
            2: v = '0;
            default: v = $urandom();
          endcase
        end
      endcase
      send_elem(v);
    end
    if (count == cur_rows * cur_cols) matrices_done++;
  endtask

  initial begin : stimulus
    fill_mode_t mode;
    int         total;
    int         pick;
    elem_ch.valid         = 1'b0;
    elem_ch.element_value = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset dimensions are the full 8x8
    send_matrix(FILL_SADDLE, 64);

    // single element matrices: extremes and a zero
    settle();
    set_dims(CFG_W'(1), CFG_W'(1));
    send_elem(INT_MAX_V);
    send_elem(INT_MIN_V);
    send_elem('0);

    // zero dimensions act as one
    settle();
    set_dims('0, '0);
    send_elem(-1);

    // 2x2: no saddle point with a zero in row 1, then all ties
    settle();
    set_dims(CFG_W'(2), CFG_W'(2));
    send_elem(1);
    send_elem(2);
    send_elem(3);
    send_elem(0);
    repeat (4) send_elem(5);

    // writes past the register list leave a partial load alone
    send_elem(7);
    send_elem(-3);
    settle();
    cfg_write(CFG_SPARE_A, '1);
    cfg_write(CFG_SPARE_B, '0);
    send_elem(9);
    send_elem(7);

    // a register write drops a partial load
    send_elem(4);
    send_elem(4);
    send_elem(4);
    settle();
    cfg_write(CFG_NUM_COLS, CFG_W'(2));
    send_elem(-8);
    send_elem(6);
    send_elem(-8);
    send_elem(6);

    // receiver holds off while several matrices are offered
    settle();
    set_dims(CFG_W'(3), CFG_W'(3));
    hold_requests++;
    repeat (3) send_matrix(FILL_SADDLE, 9);
    settle();

    // random matrices, some reconfigured, some cut short
    while (items_sent < ITEM_TARGET || matrices_done < MATRIX_TARGET) begin
      if (items_sent >= QUIET_FROM) begin
        src_gap_pct = 0;
        snk_gap_pct = 0;
      end else begin
        src_gap_pct = gap_choice();
        snk_gap_pct = gap_choice();
      end
      if ($urandom_range(0, 2) == 0) begin
        settle();
        set_dims(pick_dim(), pick_dim());
      end
      total = cur_rows * cur_cols;
      pick  = $urandom_range(0, 9);
      mode  = (pick < 4) ? FILL_TINY : (pick < 8) ? FILL_SADDLE : FILL_WIDE;
      if (total > 1 && $urandom_range(0, 9) == 0) begin
        send_matrix(mode, $urandom_range(1, total - 1));
        settle();
        cfg_write(CFG_NUM_ROWS, rows_raw);
      end else begin
        send_matrix(mode, total);
      end
    end
    elem_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (report_fails == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
